// ===== rtl/pva_pkg.sv =====
package pva_pkg;

  // Width of the signed cross product accumulators
  localparam int unsigned ACC_W = 40;
  // Width of the vertex count on the result channel
  localparam int unsigned VCNT_W = 9;
  // Width of the double area result
  localparam int unsigned AREA_W = 32;
  // Width of the sum of squares and of the root datapath
  localparam int unsigned SQ_W = 64;

  // Finished polygon handed from the front part to the back part
  typedef struct packed {
    logic signed [ACC_W-1:0] sx;
    logic signed [ACC_W-1:0] sy;
    logic signed [ACC_W-1:0] sz;
    logic                    sat;
    logic                    short_poly;
    logic [VCNT_W-1:0]       vcount;
  } pva_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } pva_qstat_t;

endpackage

// ===== rtl/pva_front.sv =====
module pva_front #(
  parameter int unsigned COORD_BITS   = 12,
  parameter int unsigned MAX_VERTICES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_px,
  input  logic signed [COORD_BITS-1:0]  in_py,
  input  logic signed [COORD_BITS-1:0]  in_pz,
  input  logic                          in_last,
  output logic                          q_push,
  output pva_pkg::pva_entry_t           q_entry,
  input  pva_pkg::pva_qstat_t           q_stat
);

  localparam int unsigned EW    = COORD_BITS + 1;
  localparam int unsigned PW    = 2 * EW;
  localparam int unsigned CW    = PW + 1;
  localparam int unsigned SW    = pva_pkg::ACC_W + 1;
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_ACC  = 2'b10
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic signed [COORD_BITS-1:0]     origin_r [3];
  logic signed [COORD_BITS-1:0]     origin_nxt [3];
  logic signed [EW-1:0]             prev_r [3];
  logic signed [EW-1:0]             prev_nxt [3];
  logic signed [EW-1:0]             edge_r [3];
  logic signed [EW-1:0]             edge_nxt [3];
  logic signed [PW-1:0]             prod_r [6];
  logic signed [PW-1:0]             prod_nxt [6];
  logic signed [pva_pkg::ACC_W-1:0] sum_r [3];
  logic signed [pva_pkg::ACC_W-1:0] sum_nxt [3];
  logic signed [pva_pkg::ACC_W-1:0] sum_upd [3];
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt, cnt_inc;
  logic                             sat_r, sat_nxt, sat_upd;
  logic                             last_r, last_nxt;

  logic signed [COORD_BITS-1:0]     pt [3];
  logic signed [CW-1:0]             cross_v [3];
  logic signed [SW-1:0]             wide [3];
  logic                             accept;
  logic                             commit;

  assign pt[0] = in_px;
  assign pt[1] = in_py;
  assign pt[2] = in_pz;

  assign in_stall = (state_r != F_IDLE);
  assign accept   = in_valid && !in_stall;
  // Hold the update while the last vertex waits for queue room
  assign commit   = (state_r == F_ACC) && (!last_r || !q_stat.full);
  assign q_push   = commit && last_r;

  // Accumulate the registered cross product with clamping
  always_comb begin
    sat_upd = sat_r;
    for (int i = 0; i < 3; i++) begin
      cross_v[i] = $signed({prod_r[2*i][PW-1], prod_r[2*i]})
                 - $signed({prod_r[2*i+1][PW-1], prod_r[2*i+1]});
      wide[i]  = $signed({sum_r[i][pva_pkg::ACC_W-1], sum_r[i]})
               + $signed({{(SW-CW){cross_v[i][CW-1]}}, cross_v[i]});
      if (wide[i][SW-1] != wide[i][SW-2]) begin
        sat_upd    = 1'b1;
        sum_upd[i] = wide[i][SW-1] ? {1'b1, {(pva_pkg::ACC_W-1){1'b0}}}
                                   : {1'b0, {(pva_pkg::ACC_W-1){1'b1}}};
      end else begin
        sum_upd[i] = wide[i][pva_pkg::ACC_W-1:0];
      end
    end
    cnt_inc = (cnt_r < CNT_W'(MAX_VERTICES)) ? cnt_r + CNT_W'(1) : cnt_r;
  end

  // Pack the finished polygon for the back part
  always_comb begin
    q_entry.sx         = sum_upd[0];
    q_entry.sy         = sum_upd[1];
    q_entry.sz         = sum_upd[2];
    q_entry.sat        = sat_upd;
    q_entry.short_poly = (cnt_inc < CNT_W'(3));
    q_entry.vcount     = pva_pkg::VCNT_W'(cnt_inc);
  end

  // Next state: edge and products on accept, sums on commit
  always_comb begin
    state_nxt = state_r;
    origin_nxt = origin_r;
    prev_nxt   = prev_r;
    edge_nxt   = edge_r;
    prod_nxt   = prod_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    sat_nxt    = sat_r;
    last_nxt   = last_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            if (cnt_r == '0) begin
              origin_nxt[i] = pt[i];
              edge_nxt[i]   = '0;
            end else begin
              edge_nxt[i] = $signed({pt[i][COORD_BITS-1], pt[i]})
                          - $signed({origin_r[i][COORD_BITS-1], origin_r[i]});
            end
          end
          prod_nxt[0] = prev_r[1] * edge_nxt[2];
          prod_nxt[1] = prev_r[2] * edge_nxt[1];
          prod_nxt[2] = prev_r[2] * edge_nxt[0];
          prod_nxt[3] = prev_r[0] * edge_nxt[2];
          prod_nxt[4] = prev_r[0] * edge_nxt[1];
          prod_nxt[5] = prev_r[1] * edge_nxt[0];
          last_nxt    = in_last;
          state_nxt   = F_ACC;
        end
      end
      F_ACC: begin
        if (commit) begin
          state_nxt = F_IDLE;
          if (last_r) begin
            // Drop the polygon state after handing it off
            for (int i = 0; i < 3; i++) begin
              origin_nxt[i] = '0;
              prev_nxt[i]   = '0;
              sum_nxt[i]    = '0;
            end
            cnt_nxt = '0;
            sat_nxt = 1'b0;
          end else begin
            prev_nxt = edge_r;
            sum_nxt  = sum_upd;
            cnt_nxt  = cnt_inc;
            sat_nxt  = sat_upd;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      for (int i = 0; i < 3; i++) begin
        origin_r[i] <= '0;
        prev_r[i]   <= '0;
        sum_r[i]    <= '0;
      end
      cnt_r  <= '0;
      sat_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      origin_r <= origin_nxt;
      prev_r   <= prev_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      sat_r    <= sat_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_r <= edge_nxt;
    prod_r <= prod_nxt;
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("front pushed into a full queue");

  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (cnt_r == '0) && !sat_r)
    else $error("polygon state not cleared after last vertex");
`endif

endmodule

// ===== rtl/pva_queue.sv =====
module pva_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pva_pkg::pva_entry_t wr_entry,
  input  logic                pop,
  output pva_pkg::pva_entry_t rd_entry,
  output pva_pkg::pva_qstat_t stat
);

  pva_pkg::pva_entry_t slot_r [2];
  logic                wptr_r, wptr_nxt;
  logic                rptr_r, rptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_entry   = slot_r[rptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wr_entry;
    end
  end

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue occupancy out of range");
`endif

endmodule

// ===== rtl/pva_back.sv =====
module pva_back (
  input  logic                               clk,
  input  logic                               rst_n,
  output logic                               q_pop,
  input  pva_pkg::pva_entry_t                q_entry,
  input  pva_pkg::pva_qstat_t                q_stat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pva_pkg::AREA_W-1:0]         out_double_area,
  output logic                               out_saturated,
  output logic [pva_pkg::VCNT_W-1:0]         out_vertex_count
);

  localparam int unsigned AW = pva_pkg::ACC_W;
  localparam int unsigned QW = pva_pkg::SQ_W;
  localparam int unsigned RW = pva_pkg::AREA_W;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_ACC  = 5'b00100,
    B_ROOT = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic signed [AW-1:0]        comp_r [3];
  logic [1:0]                  k_r, k_nxt;
  logic [QW-1:0]               prod_r, prod_nxt;
  logic [QW-1:0]               sq_r, sq_nxt;
  logic                        sq_sat_r, sq_sat_nxt;
  logic                        sat_r;
  logic                        short_r;
  logic [pva_pkg::VCNT_W-1:0]  vcount_r;
  logic [QW-1:0]               rem_r, rem_nxt;
  logic [QW-1:0]               root_r, root_nxt;
  logic [QW-1:0]               bit_r, bit_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [RW-1:0]               area_r;
  logic                        osat_r;
  logic [pva_pkg::VCNT_W-1:0]  ocount_r;

  logic [AW-1:0]               mag;
  logic [QW:0]                 sum65;
  logic                        sat_now;
  logic [QW-1:0]               trial;
  logic                        out_load;

  assign q_pop    = (state_r == B_IDLE) && !q_stat.empty;
  assign out_load = (state_r == B_OUT) && (!out_valid_r || !out_stall);

  assign mag   = comp_r[k_r][AW-1] ? AW'(-comp_r[k_r]) : comp_r[k_r];
  assign sum65 = {1'b0, sq_r} + {1'b0, prod_r};
  assign sat_now = sq_sat_r || sum65[QW];
  assign trial = root_r + bit_r;

  // Sequence squares, sum and root for one polygon
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    prod_nxt   = prod_r;
    sq_nxt     = sq_r;
    sq_sat_nxt = sq_sat_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          k_nxt      = 2'd0;
          sq_nxt     = '0;
          sq_sat_nxt = 1'b0;
          root_nxt   = '0;
          state_nxt  = q_entry.short_poly ? B_OUT : B_MUL;
        end
      end
      B_MUL: begin
        if (mag[AW-1:RW] != '0) begin
          sq_sat_nxt = 1'b1;
          prod_nxt   = '0;
        end else begin
          prod_nxt = mag[RW-1:0] * mag[RW-1:0];
        end
        state_nxt = B_ACC;
      end
      B_ACC: begin
        if (sum65[QW]) begin
          sq_sat_nxt = 1'b1;
        end else begin
          sq_nxt = sum65[QW-1:0];
        end
        if (k_r == 2'd2) begin
          rem_nxt   = sat_now ? '1 : sum65[QW-1:0];
          root_nxt  = '0;
          bit_nxt   = QW'(1) << (QW - 2);
          state_nxt = B_ROOT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = B_MUL;
        end
      end
      B_ROOT: begin
        // One result bit per cycle
        if (rem_r >= trial) begin
          rem_nxt  = rem_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == QW'(1)) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
      sq_sat_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      sq_sat_r    <= sq_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sq_r   <= sq_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    if (q_pop) begin
      comp_r[0] <= q_entry.sx;
      comp_r[1] <= q_entry.sy;
      comp_r[2] <= q_entry.sz;
      sat_r     <= q_entry.sat;
      short_r   <= q_entry.short_poly;
      vcount_r  <= q_entry.vcount;
    end
    if (out_load) begin
      area_r   <= short_r ? '0 : root_r[RW-1:0];
      osat_r   <= sat_r || sq_sat_r;
      ocount_r <= vcount_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_double_area  = area_r;
  assign out_saturated    = osat_r;
  assign out_vertex_count = ocount_r;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("back popped an empty queue");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == B_OUT))
    else $error("result raised outside the output step");

  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROOT) |-> $onehot(bit_r))
    else $error("root trial bit lost");
`endif

endmodule

// ===== rtl/polygon_3d_vector_area.sv =====
// Channel | Direction | Ports                                       | Moves
// in      | input     | in_valid in_stall in_px in_py in_pz in_last | one vertex
// out     | output    | out_valid out_stall out_double_area         | one polygon
//         |           | out_saturated out_vertex_count              |
//
// In the front part a vertex first gets its edge and six products, then the
// clamped accumulate. In the back part a polygon passes the pop, three squares
// on one 32x32 multiplier, a 32-step root, then the output register.
// A two-entry queue lets the back part overlap the next polygon's vertices.
// Reset is synchronous and clears all control state; no clearing pass runs.
// in_stall rises while a vertex is at work or the last vertex waits for room.
module polygon_3d_vector_area #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_BITS   = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_px,
  input  logic signed [COORD_BITS-1:0]       in_py,
  input  logic signed [COORD_BITS-1:0]       in_pz,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pva_pkg::AREA_W-1:0]         out_double_area,
  output logic                               out_saturated,
  output logic [pva_pkg::VCNT_W-1:0]         out_vertex_count
);

  logic                q_push;
  logic                q_pop;
  pva_pkg::pva_entry_t q_wr_entry;
  pva_pkg::pva_entry_t q_rd_entry;
  pva_pkg::pva_qstat_t q_stat;

  pva_front #(
    .COORD_BITS   (COORD_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_px    (in_px),
    .in_py    (in_py),
    .in_pz    (in_pz),
    .in_last  (in_last),
    .q_push   (q_push),
    .q_entry  (q_wr_entry),
    .q_stat   (q_stat)
  );

  pva_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .stat     (q_stat)
  );

  pva_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_pop            (q_pop),
    .q_entry          (q_rd_entry),
    .q_stat           (q_stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_double_area  (out_double_area),
    .out_saturated    (out_saturated),
    .out_vertex_count (out_vertex_count)
  );

endmodule
